/* rtl/core/hne_pkg.sv */
`default_nettype none

package hne_pkg;

  // Field and register widths.
  localparam int GRID_SIZE_W = 11;
  localparam int HEIGHT_W    = 16;
  localparam int COORD_W     = 10;
  localparam int NORMAL_W    = 16;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = 11'd256;
  localparam int MAX_GRID_DEFAULT = 1024;
  localparam int ONE_Q14 = 16384;

  // Configuration map: bit 2 of the byte address selects the register.
  localparam logic REG_GRID_SIZE = 1'b0;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Datapath widths.
  localparam int DIFF_W  = 17;  // height difference, signed
  localparam int SQ_W    = 32;  // square of a difference
  localparam int LEN_W   = 34;  // a*a + 65536 + b*b
  localparam int FRAD_W  = 50;  // face radicand, LEN_W plus 16 fraction bits
  localparam int FROOT_W = 25;  // face length
  localparam int ROOT_W  = 31;  // widest root
  localparam int REM_W   = ROOT_W + 2;
  localparam int DIV_W   = 31;  // widest divisor and partial remainder
  localparam int QUO_W   = 22;  // widest quotient
  localparam int MAG_W   = 17;  // magnitude of a face component
  localparam int SUM_W   = 25;  // sum of four unit face normals, signed
  localparam int SMAG_W  = 23;  // magnitude of a sum component
  localparam int SSQ_W   = 46;  // square of a sum component and their total
  localparam int NRAD_W  = 62;  // final radicand
  localparam int DIVD_W  = 46;  // dividend with rounding bias

  // Step counts of the iterative units.
  localparam int FSQ_STEPS = FRAD_W / 2;
  localparam int FDQ_STEPS = QUO_W;
  localparam int NSQ_STEPS = NRAD_W / 2;
  localparam int NDQ_STEPS = 16;

  localparam int FACE_SHIFT = 28;
  localparam int NORM_SHIFT = 22;
  localparam logic [MAG_W-1:0] FACE_Y_MAG = 17'd256;

  // Pipeline stage positions.
  localparam int ST_DIFF     = 0;
  localparam int ST_SQ       = 1;
  localparam int ST_RAD      = 2;
  localparam int ST_FDIV_SET = ST_RAD + FSQ_STEPS + 1;
  localparam int ST_SUM      = ST_FDIV_SET + FDQ_STEPS + 1;
  localparam int ST_SSQ      = ST_SUM + 1;
  localparam int ST_RAD2     = ST_SSQ + 1;
  localparam int ST_NDIV_SET = ST_RAD2 + NSQ_STEPS + 1;
  localparam int ST_RES      = ST_NDIV_SET + NDQ_STEPS + 1;
  localparam int PIPE_LEN    = ST_RES + 1;
  localparam int SLINE_LEN   = ST_NDIV_SET - ST_SUM;

  typedef enum logic [1:0] {
    MODE_INTERIOR,
    MODE_LAST_EDGE,
    MODE_FIRST_EDGE
  } mode_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] a1;
    logic signed [DIFF_W-1:0] a2;
    logic signed [DIFF_W-1:0] b1;
    logic signed [DIFF_W-1:0] b2;
  } diff_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  // One restoring square-root step on the next two radicand bits.
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pair);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    sqrt_t r;
    t = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (t >= trial) begin
      r.rem  = REM_W'(t - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = t[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One restoring division step on the next dividend bit.
  function automatic div_t div_step(div_t s, logic b, logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] dd;
    div_t r;
    t = {s.rem, b};
    dd = {1'b0, d};
    if (t >= dd) begin
      r.rem = DIV_W'(t - dd);
      r.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = t[DIV_W-1:0];
      r.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [SQ_W-1:0] square_diff(logic signed [DIFF_W-1:0] v);
    logic signed [2*DIFF_W-1:0] p;
    p = v * v;
    return p[SQ_W-1:0];
  endfunction

  function automatic logic [SSQ_W-1:0] square_sum(logic signed [SUM_W-1:0] v);
    logic signed [2*SUM_W-1:0] p;
    p = v * v;
    return p[SSQ_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] diff_mag(logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  function automatic logic [SMAG_W-1:0] sum_mag(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] n;
    n = -v;
    return v[SUM_W-1] ? SMAG_W'(n) : SMAG_W'(v);
  endfunction

  // Signed value of a rounded quotient.
  function automatic logic signed [SUM_W-1:0] apply_sign(logic neg, logic [QUO_W-1:0] q);
    logic signed [SUM_W-1:0] v;
    v = signed'(SUM_W'(q));
    return neg ? -v : v;
  endfunction

  // mag * 2^28 + n/2: rounds the face quotient half away from zero.
  function automatic logic [DIVD_W-1:0] face_dividend(logic [MAG_W-1:0] mag,
                                                       logic [FROOT_W-1:0] n);
    return (DIVD_W'(mag) << FACE_SHIFT) + DIVD_W'(n >> 1);
  endfunction

  // mag * 2^22 + n/2: rounds the output quotient half away from zero.
  function automatic logic [DIVD_W-1:0] norm_dividend(logic [SMAG_W-1:0] mag,
                                                       logic [ROOT_W-1:0] n);
    return (DIVD_W'(mag) << NORM_SHIFT) + DIVD_W'(n >> 1);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/heightmap_normal_estimator.sv */
`default_nettype none

// Heightmap vertex normal estimator. Each input transfer carries one grid
// vertex: its Q8.8 height, the heights of its four neighbors and its column
// and row. One output transfer follows with the unit normal in signed Q1.14,
// formed by normalizing the four face normals around the vertex, summing
// them, normalizing the sum and negating y. Vertices on the last row or
// column give (0, 16384, 0); vertices on row 0 or column 0 give zero. The
// block takes one vertex every cycle while in_stall is low; each result passes
// through 103 pipeline stages and the output register. Most stages belong
// to the bit-serial units laid out as stages: a 25-step square root and
// 22-step dividers for the faces, then a 31-step square root and 16-step
// dividers for the final normalization. grid_size sits at byte address 0 and
// is clamped to 3..MAX_GRID; write it only while no vertex is in flight.
module heightmap_normal_estimator #(
  parameter int MAX_GRID = hne_pkg::MAX_GRID_DEFAULT
) (
  input  logic clk,
  input  logic rst,

  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [hne_pkg::PADDR_W-1:0]           paddr,
  input  logic [hne_pkg::PDATA_W-1:0]           pwdata,
  output logic [hne_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [hne_pkg::HEIGHT_W-1:0]   centre_height,
  input  logic signed [hne_pkg::HEIGHT_W-1:0]   left_height,
  input  logic signed [hne_pkg::HEIGHT_W-1:0]   right_height,
  input  logic signed [hne_pkg::HEIGHT_W-1:0]   up_height,
  input  logic signed [hne_pkg::HEIGHT_W-1:0]   down_height,
  input  logic [hne_pkg::COORD_W-1:0]           column,
  input  logic [hne_pkg::COORD_W-1:0]           row,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [hne_pkg::NORMAL_W-1:0]   normal_x,
  output logic signed [hne_pkg::NORMAL_W-1:0]   normal_y,
  output logic signed [hne_pkg::NORMAL_W-1:0]   normal_z
);

  localparam int MG_W  = $clog2(MAX_GRID + 1);
  localparam int CMP_W = (MG_W > hne_pkg::GRID_SIZE_W) ? MG_W : hne_pkg::GRID_SIZE_W;
  localparam int LAST  = hne_pkg::PIPE_LEN - 1;
  localparam int FSQ   = hne_pkg::FSQ_STEPS;
  localparam int FDQ   = hne_pkg::FDQ_STEPS;
  localparam int NSQ   = hne_pkg::NSQ_STEPS;
  localparam int NDQ   = hne_pkg::NDQ_STEPS;

  // ---------------------------------------------------------------- config
  logic [hne_pkg::GRID_SIZE_W-1:0] grid_size;
  logic                            cfg_sel;

  assign cfg_sel = (paddr[2] == hne_pkg::REG_GRID_SIZE);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? hne_pkg::PDATA_W'(grid_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= hne_pkg::GRID_SIZE_RESET;
    end else if (psel && penable && pwrite && cfg_sel) begin
      grid_size <= pwdata[hne_pkg::GRID_SIZE_W-1:0];
    end
  end

  // ---------------------------------------------------------- flow control
  // The whole pipeline advances together. It holds only when the last stage
  // carries a result and the output register still waits on its transfer.
  logic                          en;
  logic [hne_pkg::PIPE_LEN-1:0]  vld;
  hne_pkg::mode_t                mode_q [hne_pkg::PIPE_LEN];

  assign en       = !vld[LAST] || !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[hne_pkg::PIPE_LEN-2:0], in_valid};
    end
  end

  // Classify the vertex against the clamped grid size. The last row and
  // column win over the first.
  logic [CMP_W-1:0] size_c;
  logic [CMP_W-1:0] last_idx;
  hne_pkg::mode_t   mode_in;

  always_comb begin
    if (CMP_W'(grid_size) < CMP_W'(3)) begin
      size_c = CMP_W'(3);
    end else if (CMP_W'(grid_size) > CMP_W'(MAX_GRID)) begin
      size_c = CMP_W'(MAX_GRID);
    end else begin
      size_c = CMP_W'(grid_size);
    end
    last_idx = size_c - CMP_W'(1);
    if (CMP_W'(row) >= last_idx || CMP_W'(column) >= last_idx) begin
      mode_in = hne_pkg::MODE_LAST_EDGE;
    end else if (row == '0 || column == '0) begin
      mode_in = hne_pkg::MODE_FIRST_EDGE;
    end else begin
      mode_in = hne_pkg::MODE_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_q[0] <= mode_in;
      for (int k = 1; k < hne_pkg::PIPE_LEN; k++) begin
        mode_q[k] <= mode_q[k-1];
      end
    end
  end

  // ------------------------------------------------- differences, squares
  hne_pkg::diff_t           dq  [hne_pkg::ST_FDIV_SET];
  logic [hne_pkg::SQ_W-1:0] sq  [4];   // a1, a2, b1, b2
  logic [hne_pkg::FRAD_W-1:0] rad [4]; // one per face

  always_ff @(posedge clk) begin
    if (en) begin
      dq[0].a1 <= hne_pkg::DIFF_W'(centre_height) - hne_pkg::DIFF_W'(left_height);
      dq[0].a2 <= hne_pkg::DIFF_W'(right_height) - hne_pkg::DIFF_W'(centre_height);
      dq[0].b1 <= hne_pkg::DIFF_W'(centre_height) - hne_pkg::DIFF_W'(up_height);
      dq[0].b2 <= hne_pkg::DIFF_W'(down_height) - hne_pkg::DIFF_W'(centre_height);
      for (int k = 1; k < hne_pkg::ST_FDIV_SET; k++) begin
        dq[k] <= dq[k-1];
      end
      sq[0] <= hne_pkg::square_diff(dq[0].a1);
      sq[1] <= hne_pkg::square_diff(dq[0].a2);
      sq[2] <= hne_pkg::square_diff(dq[0].b1);
      sq[3] <= hne_pkg::square_diff(dq[0].b2);
      // Faces: (a1,b1) (a1,b2) (a2,b2) (a2,b1); radicand is len2 * 2^16.
      for (int f = 0; f < 4; f++) begin
        rad[f] <= {hne_pkg::LEN_W'(sq[(f < 2) ? 0 : 1])
                   + hne_pkg::LEN_W'(sq[(f == 0 || f == 3) ? 2 : 3])
                   + hne_pkg::LEN_W'(65536), 16'd0};
      end
    end
  end

  // ------------------------------------------------------ face lengths
  hne_pkg::sqrt_t             fsq  [FSQ][4];
  logic [hne_pkg::FRAD_W-1:0] frad [FSQ-1][4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int f = 0; f < 4; f++) begin
        fsq[0][f]  <= hne_pkg::sqrt_step('0, rad[f][hne_pkg::FRAD_W-1 -: 2]);
        frad[0][f] <= rad[f] << 2;
        for (int k = 1; k < FSQ; k++) begin
          fsq[k][f] <= hne_pkg::sqrt_step(fsq[k-1][f], frad[k-1][f][hne_pkg::FRAD_W-1 -: 2]);
        end
        for (int k = 1; k < FSQ - 1; k++) begin
          frad[k][f] <= frad[k-1][f] << 2;
        end
      end
    end
  end

  // --------------------------------------------------- face unit vectors
  // Twelve dividers: x, y, z of each face over that face's length.
  hne_pkg::diff_t             dl;
  logic [hne_pkg::FROOT_W-1:0] flen [4];
  logic [hne_pkg::MAG_W-1:0]  fmag [4][3];
  logic                       fneg [4][3];
  logic [hne_pkg::DIVD_W-1:0] fdvd [4][3];

  always_comb begin
    dl = dq[hne_pkg::ST_FDIV_SET-1];
    for (int f = 0; f < 4; f++) begin
      flen[f] = fsq[FSQ-1][f].root[hne_pkg::FROOT_W-1:0];
      fmag[f][0] = hne_pkg::diff_mag((f < 2) ? dl.a1 : dl.a2);
      fneg[f][0] = (f < 2) ? dl.a1[hne_pkg::DIFF_W-1] : dl.a2[hne_pkg::DIFF_W-1];
      fmag[f][1] = hne_pkg::FACE_Y_MAG;
      fneg[f][1] = 1'b1;
      fmag[f][2] = hne_pkg::diff_mag((f == 0 || f == 3) ? dl.b1 : dl.b2);
      fneg[f][2] = (f == 0 || f == 3) ? dl.b1[hne_pkg::DIFF_W-1] : dl.b2[hne_pkg::DIFF_W-1];
      for (int c = 0; c < 3; c++) begin
        fdvd[f][c] = hne_pkg::face_dividend(fmag[f][c], flen[f]);
      end
    end
  end

  hne_pkg::div_t               fdv [FDQ+1][4][3];
  logic [FDQ-1:0]              flo [FDQ][4][3];
  logic [hne_pkg::FROOT_W-1:0] fdn [FDQ][4];
  logic                        fsg [FDQ+1][4][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int f = 0; f < 4; f++) begin
        fdn[0][f] <= flen[f];
        for (int k = 1; k < FDQ; k++) begin
          fdn[k][f] <= fdn[k-1][f];
        end
        for (int c = 0; c < 3; c++) begin
          // Seed with the top dividend bits; the quotient fits in FDQ bits.
          fdv[0][f][c] <= '{rem: hne_pkg::DIV_W'(fdvd[f][c][hne_pkg::DIVD_W-1:FDQ]),
                            quo: '0};
          flo[0][f][c] <= fdvd[f][c][FDQ-1:0];
          fsg[0][f][c] <= fneg[f][c];
          for (int k = 1; k <= FDQ; k++) begin
            fdv[k][f][c] <= hne_pkg::div_step(fdv[k-1][f][c], flo[k-1][f][c][FDQ-1],
                                              hne_pkg::DIV_W'(fdn[k-1][f]));
            fsg[k][f][c] <= fsg[k-1][f][c];
          end
          for (int k = 1; k < FDQ; k++) begin
            flo[k][f][c] <= flo[k-1][f][c] << 1;
          end
        end
      end
    end
  end

  // ------------------------------------------------- sum and its length
  logic signed [hne_pkg::SUM_W-1:0] s_next [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s_next[c] = '0;
      for (int f = 0; f < 4; f++) begin
        s_next[c] = s_next[c] + hne_pkg::apply_sign(fsg[FDQ][f][c], fdv[FDQ][f][c].quo);
      end
    end
  end

  logic signed [hne_pkg::SUM_W-1:0] sl   [hne_pkg::SLINE_LEN][3];
  logic [hne_pkg::SSQ_W-1:0]        ssq  [3];
  logic [hne_pkg::NRAD_W-1:0]       rad2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sl[0][c] <= s_next[c];
        for (int k = 1; k < hne_pkg::SLINE_LEN; k++) begin
          sl[k][c] <= sl[k-1][c];
        end
        ssq[c] <= hne_pkg::square_sum(sl[0][c]);
      end
      rad2 <= {ssq[0] + ssq[1] + ssq[2], 16'd0};
    end
  end

  hne_pkg::sqrt_t             nsq  [NSQ];
  logic [hne_pkg::NRAD_W-1:0] nrad [NSQ-1];

  always_ff @(posedge clk) begin
    if (en) begin
      nsq[0]  <= hne_pkg::sqrt_step('0, rad2[hne_pkg::NRAD_W-1 -: 2]);
      nrad[0] <= rad2 << 2;
      for (int k = 1; k < NSQ; k++) begin
        nsq[k] <= hne_pkg::sqrt_step(nsq[k-1], nrad[k-1][hne_pkg::NRAD_W-1 -: 2]);
      end
      for (int k = 1; k < NSQ - 1; k++) begin
        nrad[k] <= nrad[k-1] << 2;
      end
    end
  end

  // ------------------------------------------------- final normalization
  logic [hne_pkg::DIVD_W-1:0] ndvd [3];
  logic [hne_pkg::ROOT_W-1:0] nlen;

  always_comb begin
    nlen = nsq[NSQ-1].root;
    for (int c = 0; c < 3; c++) begin
      ndvd[c] = hne_pkg::norm_dividend(hne_pkg::sum_mag(sl[hne_pkg::SLINE_LEN-1][c]), nlen);
    end
  end

  hne_pkg::div_t              ndv [NDQ+1][3];
  logic [NDQ-1:0]             nlo [NDQ][3];
  logic [hne_pkg::ROOT_W-1:0] ndn [NDQ];
  logic                       nsg [NDQ+1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      ndn[0] <= nlen;
      for (int k = 1; k < NDQ; k++) begin
        ndn[k] <= ndn[k-1];
      end
      for (int c = 0; c < 3; c++) begin
        ndv[0][c] <= '{rem: hne_pkg::DIV_W'(ndvd[c][hne_pkg::DIVD_W-1:NDQ]), quo: '0};
        nlo[0][c] <= ndvd[c][NDQ-1:0];
        nsg[0][c] <= sl[hne_pkg::SLINE_LEN-1][c][hne_pkg::SUM_W-1];
        for (int k = 1; k <= NDQ; k++) begin
          ndv[k][c] <= hne_pkg::div_step(ndv[k-1][c], nlo[k-1][c][NDQ-1],
                                         hne_pkg::DIV_W'(ndn[k-1]));
          nsg[k][c] <= nsg[k-1][c];
        end
        for (int k = 1; k < NDQ; k++) begin
          nlo[k][c] <= nlo[k-1][c] << 1;
        end
      end
    end
  end

  // Saturate, negate y, then let the edge cases override.
  logic [NDQ-1:0]                      qsat [3];
  logic signed [hne_pkg::NORMAL_W-1:0] qval [3];
  logic signed [hne_pkg::NORMAL_W-1:0] res_next [3];
  logic signed [hne_pkg::NORMAL_W-1:0] res [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qsat[c] = (ndv[NDQ][c].quo[NDQ-1:0] > NDQ'(hne_pkg::ONE_Q14))
              ? NDQ'(hne_pkg::ONE_Q14) : ndv[NDQ][c].quo[NDQ-1:0];
      qval[c] = signed'(hne_pkg::NORMAL_W'(qsat[c]));
    end
    case (mode_q[hne_pkg::ST_RES-1])
      hne_pkg::MODE_LAST_EDGE: begin
        res_next[0] = '0;
        res_next[1] = hne_pkg::NORMAL_W'(hne_pkg::ONE_Q14);
        res_next[2] = '0;
      end
      hne_pkg::MODE_FIRST_EDGE: begin
        res_next[0] = '0;
        res_next[1] = '0;
        res_next[2] = '0;
      end
      default: begin
        res_next[0] = nsg[NDQ][0] ? -qval[0] : qval[0];
        res_next[1] = nsg[NDQ][1] ? qval[1] : -qval[1];
        res_next[2] = nsg[NDQ][2] ? -qval[2] : qval[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        res[c] <= res_next[c];
      end
    end
  end

  // --------------------------------------------------------- output stage
  // Hold the result until its transfer; the pipeline keeps moving behind it
  // as long as its last stage is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && vld[LAST]) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[LAST]) begin
      normal_x <= res[0];
      normal_y <= res[1];
      normal_z <= res[2];
    end
  end

endmodule

`default_nettype wire

/* tb/tb_heightmap_normal_estimator.sv */
`default_nettype none

module tb_heightmap_normal_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 104;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] hc, hl, hr, hu, hd;
    logic [9:0] col, row;
  } vertex_t;

  typedef struct {
    logic signed [15:0] x, y, z;
  } normal_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [hne_pkg::PADDR_W-1:0] paddr = '0;
  logic [hne_pkg::PDATA_W-1:0] pwdata = '0;
  logic [hne_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] centre_height = 0, left_height = 0, right_height = 0;
  logic signed [15:0] up_height = 0, down_height = 0;
  logic [9:0] column = 0, row = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] normal_x, normal_y, normal_z;

  heightmap_normal_estimator DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Grid size as last written, held by the predictor.
  logic [10:0] grid_size_shadow = 11'd256;

  // Stall seen at the last rising edge, so the driver knows if the transfer took place.
  logic in_stall_q = 0;

  vertex_t pending_vertices[$];
  normal_t expected_normals[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet_stretch = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Round num * 2^sh / den half away from zero.
  function automatic longint round_div(longint num, int sh, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    if (den == 0) return 0;
    mag = (num < 0) ? longint'(-num) : num;
    mag <<= sh;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip_q14(longint v);
    if (v > hne_pkg::ONE_Q14) return hne_pkg::ONE_Q14;
    if (v < -hne_pkg::ONE_Q14) return -hne_pkg::ONE_Q14;
    return v;
  endfunction

  // Accumulate one unit face normal (a, -1, b) into the running sum.
  function automatic void add_unit_face(longint a, longint b, ref longint s[3]);
    longint unsigned n;
    n = int_sqrt(longint'(a * a + 65536 + b * b) << 16);
    s[0] += round_div(a, 28, n);
    s[1] += round_div(-256, 28, n);
    s[2] += round_div(b, 28, n);
  endfunction

  function automatic normal_t vertex_normal(vertex_t v);
    normal_t r;
    longint s[3];
    longint h, sz, last;
    longint unsigned n;
    r.x = 0; r.y = 0; r.z = 0;
    s[0] = 0; s[1] = 0; s[2] = 0;
    h = v.hc;
    sz = grid_size_shadow;
    if (sz < 3) sz = 3;
    if (sz > hne_pkg::MAX_GRID_DEFAULT) sz = hne_pkg::MAX_GRID_DEFAULT;
    last = sz - 1;
    if (v.row >= last || v.col >= last) begin
      r.y = 16'(hne_pkg::ONE_Q14);
    end else if (v.row != 0 && v.col != 0) begin
      add_unit_face(h - v.hl, h - v.hu, s);
      add_unit_face(h - v.hl, v.hd - h, s);
      add_unit_face(v.hr - h, v.hd - h, s);
      add_unit_face(v.hr - h, h - v.hu, s);
      n = int_sqrt(longint'(s[0] * s[0] + s[1] * s[1] + s[2] * s[2]) << 16);
      if (n != 0) begin
        r.x = 16'(clip_q14(round_div(s[0], 22, n)));
        r.y = 16'(clip_q14(-round_div(s[1], 22, n)));
        r.z = 16'(clip_q14(round_div(s[2], 22, n)));
      end
    end
    return r;
  endfunction

  function automatic bit take_gap();
    return !quiet_stretch && ($urandom_range(99) < 9);
  endfunction

  // Driver: present the next vertex, hold it while stalled.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        // transfer happened at the last rising edge; advance
        void'(pending_vertices.pop_front());
      end
      if ((in_valid && in_stall_q) || (!take_gap() && pending_vertices.size() > 0)) begin
        if (!(in_valid && in_stall_q)) begin
          centre_height <= pending_vertices[0].hc;
          left_height   <= pending_vertices[0].hl;
          right_height  <= pending_vertices[0].hr;
          up_height     <= pending_vertices[0].hu;
          down_height   <= pending_vertices[0].hd;
          column        <= pending_vertices[0].col;
          row           <= pending_vertices[0].row;
        end
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
      out_stall <= take_gap();
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk) begin
    normal_t got, want;
    cycles <= cycles + 1;
    in_stall_q <= in_stall;
    if (!rst && in_valid && !in_stall)
      expected_normals = {expected_normals, vertex_normal(pending_vertices[0])};
    if (!rst && out_valid && !out_stall) begin
      got.x = normal_x; got.y = normal_y; got.z = normal_z;
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal %0d %0d %0d", got.x, got.y, got.z);
      end else begin
        want = expected_normals.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     want.x, want.y, want.z, got.x, got.y, got.z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_grid_size(logic [10:0] value);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    grid_size_shadow = value;
  endtask

  // Wait for the pipe to drain before touching the register.
  task automatic drain();
    while (pending_vertices.size() > 0 || expected_normals.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic queue_vertex(logic [15:0] hc, hl, hr, hu, hd, logic [9:0] col, rw);
    vertex_t v;
    v.hc = hc; v.hl = hl; v.hr = hr; v.hu = hu; v.hd = hd; v.col = col; v.row = rw;
    pending_vertices = {pending_vertices, v};
  endtask

  function automatic logic [15:0] rand_height();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(int count, int lim);
    logic [15:0] base;
    repeat (count) begin
      base = rand_height();
      if ($urandom_range(3) == 0)
        queue_vertex(base, rand_height(), rand_height(), rand_height(), rand_height(),
                     10'($urandom), 10'($urandom));
      else
        queue_vertex(base, base + 16'($urandom_range(2047)) - 16'd1024,
                     base + 16'($urandom_range(2047)) - 16'd1024,
                     base + 16'($urandom_range(2047)) - 16'd1024,
                     base + 16'($urandom_range(2047)) - 16'd1024,
                     10'($urandom_range(lim)), 10'($urandom_range(lim)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: flat, extremes of heights, interior, first-edge and last-edge vertices.
    queue_vertex(0, 0, 0, 0, 0, 5, 5);
    queue_vertex(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 1);
    queue_vertex(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 254, 254);
    queue_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 100, 7);
    queue_vertex(256, 0, 512, 0, 512, 10, 10);
    queue_vertex(100, 1, 2, 3, 4, 0, 5);
    queue_vertex(100, 1, 2, 3, 4, 5, 0);
    queue_vertex(100, 1, 2, 3, 4, 255, 5);
    queue_vertex(100, 1, 2, 3, 4, 5, 255);
    queue_vertex(100, 1, 2, 3, 4, 1023, 1023);
    queue_vertex(-1, -1, -1, -1, -1, 0, 1023);
    queue_random(600, 300);
    drain();

    // Extremes: smallest grid, then size 0 (clamped up), then beyond MAX_GRID, then MAX_GRID and 37.
    write_grid_size(11'd3);
    queue_vertex(5, 1, 9, -3, 7, 1, 1);
    queue_random(300, 3);
    drain();
    write_grid_size(11'd0);
    queue_random(100, 3);
    drain();
    write_grid_size(11'h7FF);
    queue_vertex(5, 1, 9, -3, 7, 1022, 1021);
    quiet_stretch = 1;
    queue_random(300, 1023);
    drain();
    quiet_stretch = 0;
    write_grid_size(11'd1024);
    queue_random(300, 1023);
    drain();
    write_grid_size(11'd37);
    queue_random(330, 40);
    drain();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

`default_nettype wire
